>>> sv/midi_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the MIDI channel message parser.
`default_nettype none

package midi_pkg;

   // Field widths of the request, response and register beats.
   localparam int ByteW    = 8;
   localparam int DataW    = 7;
   localparam int ChanW    = 4;
   localparam int KindW    = 4;
   localparam int ValueW   = 14;
   localparam int CsrDataW = 32;
   localparam int CsrAddrW = 3;

   // Register indexes on the configuration port.
   localparam logic [CsrAddrW-3:0] RegListenChannel = 1'b0;

   // Event codes carried on the response channel.
   typedef enum logic [KindW-1:0] {
      EV_NOTEOFF  = 4'd0,
      EV_NOTEON   = 4'd1,
      EV_BEND     = 4'd2,
      EV_CC       = 4'd3,
      EV_MODE     = 4'd4,
      EV_PROGRAM  = 4'd5,
      EV_CLOCK    = 4'd6,
      EV_START    = 4'd7,
      EV_CONTINUE = 4'd8,
      EV_STOP     = 4'd9,
      EV_SENSING  = 4'd10,
      EV_RESET    = 4'd11
   } event_kind_type;

   // Status and realtime byte values.
   localparam logic [ByteW-1:0] ByteSysexStart = 8'hF0;
   localparam logic [ByteW-1:0] ByteSysexEnd   = 8'hF7;
   localparam logic [ByteW-1:0] ByteClock      = 8'hF8;
   localparam logic [ByteW-1:0] ByteStart      = 8'hFA;
   localparam logic [ByteW-1:0] ByteContinue   = 8'hFB;
   localparam logic [ByteW-1:0] ByteStop       = 8'hFC;
   localparam logic [ByteW-1:0] ByteSensing    = 8'hFE;
   localparam logic [ByteW-1:0] ByteReset      = 8'hFF;

   // Upper nibble of the channel voice status bytes.
   localparam logic [3:0] NibNoteOff = 4'h8;
   localparam logic [3:0] NibNoteOn  = 4'h9;
   localparam logic [3:0] NibCc      = 4'hB;
   localparam logic [3:0] NibProgram = 4'hC;
   localparam logic [3:0] NibBend    = 4'hE;

   // Controllers from this number up are channel mode messages.
   localparam logic [DataW-1:0] ModeFirstControl = 7'd120;
   // Velocity reported for a note on with velocity zero.
   localparam logic [DataW-1:0] DefaultOffVelocity = 7'd64;

endpackage

`default_nettype wire

>>> sv/midi_channel_message_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the MIDI channel message parser with running status.
`default_nettype none

//  channel | direction | handshake                          | payload
//  req     | in        | req_valid / req_ready              | req_rx_byte
//  rsp     | out       | rsp_valid / rsp_ready              | event kind, key, value
//  csr     | in/out    | APB csr_psel/penable/pwrite/pready | listen_channel at 0x0
//
// An accepted byte sits in the input register while the parse logic works on it; its
// response beat then loads the result register. A byte can be accepted every cycle
// while no response stalls. Reset puts the parser in its ignore phase outside sysex.
// A stalled response holds the input register, and the input register in turn
// drops req_ready; a byte that produces no event still waits for a free output.

module midi_channel_message_parser_unit (
   input  wire  logic                           clock,
   input  wire  logic                           reset,
   // Request channel
   input  wire  logic                           req_valid,
   output logic                                 req_ready,
   input  wire  logic [midi_pkg::ByteW-1:0]     req_rx_byte,
   // Response channel
   output logic                                 rsp_valid,
   input  wire  logic                           rsp_ready,
   output logic [midi_pkg::KindW-1:0]           rsp_event_kind,
   output logic [midi_pkg::DataW-1:0]           rsp_key_or_control,
   output logic [midi_pkg::ValueW-1:0]          rsp_event_value,
   // Configuration port
   input  wire  logic                           csr_psel,
   input  wire  logic                           csr_penable,
   input  wire  logic                           csr_pwrite,
   input  wire  logic [midi_pkg::CsrAddrW-1:0]  csr_paddr,
   input  wire  logic [midi_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [midi_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [3:0] {
      PH_STATUS = 4'd0,
      PH_OFF_A  = 4'd1,
      PH_OFF_B  = 4'd2,
      PH_ON_A   = 4'd3,
      PH_ON_B   = 4'd4,
      PH_BEND_A = 4'd5,
      PH_BEND_B = 4'd6,
      PH_CC_A   = 4'd7,
      PH_CC_B   = 4'd8,
      PH_PROG   = 4'd9,
      PH_COMMON = 4'd10,
      PH_IGNORE = 4'd11
   } phase_type;

   // Configuration register.
   logic [midi_pkg::ChanW-1:0] listen_ff, listen_in;
   logic                       csr_write;
   logic                       csr_hit;

   // Input register.
   logic                       s1_valid_ff, s1_valid_in;
   logic [midi_pkg::ByteW-1:0] s1_byte_ff, s1_byte_in;
   logic                       s1_move;
   logic                       can_load;

   // Parser state.
   phase_type                  phase_ff, phase_in;
   logic                       sysex_ff, sysex_in;
   logic [midi_pkg::DataW-1:0] first_ff, first_in;
   logic [midi_pkg::DataW-1:0] second_ff, second_in;
   logic [midi_pkg::ChanW-1:0] chan_ff, chan_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [midi_pkg::KindW-1:0]  kind_ff, kind_in;
   logic [midi_pkg::DataW-1:0]  key_ff, key_in;
   logic [midi_pkg::ValueW-1:0] value_ff, value_in;

   // Parse logic working signals.
   logic                       produce;
   logic                       mine;
   logic                       second_phase;
   phase_type                  phase_work;
   logic [midi_pkg::ByteW-1:0] b;

   // Register access: any write with address bit 2 clear hits listen_channel.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[midi_pkg::CsrAddrW-1:2] == midi_pkg::RegListenChannel);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign listen_in  = csr_write ? csr_pwdata[midi_pkg::ChanW-1:0] : listen_ff;
   assign csr_prdata = csr_hit ? {{(midi_pkg::CsrDataW-midi_pkg::ChanW){1'b0}}, listen_ff}
                               : '0;

   // Handshake: the input register moves whenever the output register can load.
   assign can_load    = !rsp_valid_ff || rsp_ready;
   assign s1_move     = s1_valid_ff && can_load;
   assign req_ready   = !s1_valid_ff || can_load;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_move);
   assign s1_byte_in  = (req_valid && req_ready) ? req_rx_byte : s1_byte_ff;
   assign b           = s1_byte_ff;

   // Parse one byte against the current state.
   always_comb begin
      phase_in     = phase_ff;
      sysex_in     = sysex_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      chan_in      = chan_ff;
      produce      = 1'b0;
      kind_in      = kind_ff;
      key_in       = '0;
      value_in     = '0;
      phase_work   = phase_ff;
      mine         = 1'b0;
      second_phase = (phase_ff == PH_OFF_B) || (phase_ff == PH_ON_B) ||
                     (phase_ff == PH_BEND_B) || (phase_ff == PH_CC_B) ||
                     (phase_ff == PH_IGNORE);
      if (sysex_ff) begin
         // Everything inside system exclusive is swallowed until its end byte.
         if (b == midi_pkg::ByteSysexEnd) begin
            sysex_in = 1'b0;
         end
      end else if (b >= midi_pkg::ByteClock) begin
         // Realtime bytes leave the phase alone; the defined ones report an event.
         produce = 1'b1;
         unique case (b)
            midi_pkg::ByteClock:    kind_in = midi_pkg::EV_CLOCK;
            midi_pkg::ByteStart:    kind_in = midi_pkg::EV_START;
            midi_pkg::ByteContinue: kind_in = midi_pkg::EV_CONTINUE;
            midi_pkg::ByteStop:     kind_in = midi_pkg::EV_STOP;
            midi_pkg::ByteSensing:  kind_in = midi_pkg::EV_SENSING;
            midi_pkg::ByteReset:    kind_in = midi_pkg::EV_RESET;
            default:                produce = 1'b0;
         endcase
      end else begin
         // Store the byte: channel status bytes set phase and channel, system bytes the phase, data bytes a slot.
         if (b >= midi_pkg::ByteSysexStart) begin
            if (b == midi_pkg::ByteSysexStart) begin
               sysex_in = 1'b1;
            end
            phase_work = PH_COMMON;
         end else if (b[7]) begin
            chan_in    = b[3:0];
            phase_work = (b[3:0] == listen_ff) ? PH_STATUS : PH_IGNORE;
         end else if (second_phase) begin
            second_in = b[6:0];
         end else begin
            first_in = b[6:0];
         end
         mine     = (chan_in == listen_ff);
         phase_in = phase_work;
         // Advance the message phase and report completed messages.
         unique case (phase_work)
            PH_STATUS: begin
               unique case (b[7:4])
                  midi_pkg::NibNoteOff: phase_in = PH_OFF_A;
                  midi_pkg::NibNoteOn:  phase_in = PH_ON_A;
                  midi_pkg::NibBend:    phase_in = PH_BEND_A;
                  midi_pkg::NibCc:      phase_in = PH_CC_A;
                  midi_pkg::NibProgram: phase_in = PH_PROG;
                  default:              phase_in = PH_IGNORE;
               endcase
            end
            PH_OFF_A:  phase_in = PH_OFF_B;
            PH_OFF_B: begin
               phase_in = PH_OFF_A;
               produce  = mine;
               kind_in  = midi_pkg::EV_NOTEOFF;
               key_in   = first_in;
               value_in = {{(midi_pkg::ValueW-midi_pkg::DataW){1'b0}}, second_in};
            end
            PH_ON_A:   phase_in = PH_ON_B;
            PH_ON_B: begin
               phase_in = PH_ON_A;
               produce  = mine;
               key_in   = first_in;
               if (second_in == '0) begin
                  kind_in  = midi_pkg::EV_NOTEOFF;
                  value_in = {{(midi_pkg::ValueW-midi_pkg::DataW){1'b0}},
                              midi_pkg::DefaultOffVelocity};
               end else begin
                  kind_in  = midi_pkg::EV_NOTEON;
                  value_in = {{(midi_pkg::ValueW-midi_pkg::DataW){1'b0}}, second_in};
               end
            end
            PH_BEND_A: phase_in = PH_BEND_B;
            PH_BEND_B: begin
               phase_in = PH_BEND_A;
               produce  = mine;
               kind_in  = midi_pkg::EV_BEND;
               value_in = {second_in, first_in};
            end
            PH_CC_A:   phase_in = PH_CC_B;
            PH_CC_B: begin
               phase_in = PH_CC_A;
               produce  = mine;
               kind_in  = (first_in < midi_pkg::ModeFirstControl) ? midi_pkg::EV_CC
                                                                   : midi_pkg::EV_MODE;
               key_in   = first_in;
               value_in = {{(midi_pkg::ValueW-midi_pkg::DataW){1'b0}}, second_in};
            end
            PH_PROG: begin
               produce  = mine;
               kind_in  = midi_pkg::EV_PROGRAM;
               value_in = {{(midi_pkg::ValueW-midi_pkg::DataW){1'b0}}, first_in};
            end
            default: phase_in = phase_work;
         endcase
      end
   end

   // Output valid: load on a move, otherwise clear once the beat is taken.
   always_comb begin
      if (s1_move) begin
         rsp_valid_in = produce;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IGNORE;
         sysex_ff     <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
         chan_ff      <= '0;
      end else begin
         listen_ff    <= listen_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            phase_ff  <= phase_in;
            sysex_ff  <= sysex_in;
            first_ff  <= first_in;
            second_ff <= second_in;
            chan_ff   <= chan_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      if (s1_move && produce) begin
         kind_ff  <= kind_in;
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_key_or_control = key_ff;
   assign rsp_event_value    = value_ff;

   // A byte stuck in the input register blocks the request side.
   a_hold_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !can_load) |-> !req_ready)
      else $error("request accepted while input register is stalled");

   // Bytes inside system exclusive never produce a response beat.
   a_sysex_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_move && sysex_ff) |=> !rsp_valid_ff)
      else $error("response produced inside system exclusive");

   // Realtime events carry zero key and value.
   a_realtime_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff >= midi_pkg::EV_CLOCK))
      |-> (key_ff == '0 && value_ff == '0))
      else $error("realtime event with nonzero payload");

   // The status phase lasts only within the parse of one byte.
   a_no_status_rest: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_STATUS)
      else $error("parser rests in status phase");

endmodule

`default_nettype wire
